// File: hdl/scc_pkg.sv
// Shared types and constants for the strongly connected component counter.
package scc_pkg;

  localparam int unsigned VertexWidth = 8;
  localparam int unsigned CountWidth  = 9;
  localparam int unsigned MaxVertices = 256;
  localparam int unsigned MaxEdges    = 1024;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_RUN  = 1'b1
  } kind_e;

  // Classified command passed from the front end to the walk engine.
  typedef struct packed {
    logic                   run;
    logic                   keep;
    logic [VertexWidth-1:0] from_vertex;
    logic [VertexWidth-1:0] to_vertex;
  } cmd_t;

endpackage

// File: hdl/scc_if.sv
// Valid/ready channel interfaces for input items and results.
interface scc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] from_vertex;
  logic [7:0] to_vertex;
  modport source (output valid, kind, from_vertex, to_vertex, input ready);
  modport sink (input valid, kind, from_vertex, to_vertex, output ready);
endinterface

interface scc_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] component_count;
  logic       dropped_edges;
  modport source (output valid, component_count, dropped_edges, input ready);
  modport sink (input valid, component_count, dropped_edges, output ready);
endinterface

// File: hdl/scc_ram.sv
// Generic single-port RAM with registered read data.
module scc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: hdl/scc_front.sv
// Front end: accepts items, range checks edges and queues commands.
module scc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  scc_in_if.sink        in_ch,
  input  logic [8:0]    vertex_count_i,
  output logic          cmd_valid_o,
  output scc_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  localparam int unsigned QDepth = 4;

  scc_pkg::cmd_t q_q [QDepth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic [9:0] live;
  logic       push;
  scc_pkg::cmd_t cmd;

  always_comb begin
    live = (10'(vertex_count_i) > 10'(scc_pkg::MaxVertices)) ? 10'(scc_pkg::MaxVertices)
                                                             : 10'(vertex_count_i);
    cmd.run         = (in_ch.kind == scc_pkg::KIND_RUN);
    cmd.from_vertex = in_ch.from_vertex;
    cmd.to_vertex   = in_ch.to_vertex;
    cmd.keep        = (10'(in_ch.from_vertex) < live) && (10'(in_ch.to_vertex) < live);
  end

  assign in_ch.ready = (cnt_q != 3'(QDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid_o = (cnt_q != 3'd0);
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 2'd1;
      end
      if (cmd_pop_i) begin
        rd_q <= rd_q + 2'd1;
      end
      cnt_q <= cnt_q + 3'(push) - 3'(cmd_pop_i);
    end
  end
endmodule

// File: hdl/scc_engine.sv
// Back end: stores edges and runs both depth-first walks of Kosaraju's method.
module scc_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [8:0]    vertex_count_i,
  input  logic          cmd_valid_i,
  input  scc_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  scc_out_if.source     out_ch
);
  localparam int unsigned MaxVertices = scc_pkg::MaxVertices;
  localparam int unsigned MaxEdges    = scc_pkg::MaxEdges;
  localparam int unsigned EW = $clog2(MaxEdges);
  localparam int unsigned ETW = $clog2(MaxEdges + 1);
  localparam int unsigned SW = $clog2(MaxVertices);
  localparam int unsigned STW = $clog2(MaxVertices + 1);

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CHK_RD, ST_CHK, ST_CLR, ST_OUTER, ST_OUTER_CHK, ST_TOP_RD,
    ST_TOP, ST_EDGE_RD, ST_EDGE, ST_VIS, ST_PUSH, ST_POP, ST_PASS2, ST_FIN_RD, ST_FIN,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   backward_q;
  logic   mark_q;
  logic [ETW-1:0] edge_total_q, e_q;
  logic [STW-1:0] depth_q, fin_total_q, i_q;
  logic [8:0]     count_q;
  logic           drop_q;
  logic [7:0]     v_q, b_q;
  logic [9:0]     live;

  // Edge store, finish list, walk stack and visited mark RAM controls.
  logic            ef_we, st_we, fl_we, vis_we;
  logic [EW-1:0]   e_addr;
  logic [7:0]      ef_rd, et_rd, fl_rd, fl_wd;
  logic [SW-1:0]   st_addr, fl_addr, vis_addr;
  logic [8+ETW-1:0] st_wd, st_rd;
  logic            vis_wd, vis_rd;

  logic [7:0] a_v, b_v;
  assign a_v = backward_q ? et_rd : ef_rd;
  assign b_v = backward_q ? ef_rd : et_rd;

  always_comb begin
    live = (10'(vertex_count_i) > 10'(MaxVertices)) ? 10'(MaxVertices)
                                                    : 10'(vertex_count_i);
  end

  // Pass one marks vertices with 1 and pass two marks them back to 0, so the
  // marks are all clear again after every run.
  logic vis_hit;
  assign vis_hit = (vis_rd == mark_q);

  logic edge_hit;
  assign edge_hit = (e_q < edge_total_q) && (a_v == v_q) && (10'(a_v) < live)
                    && (10'(b_v) < live);

  logic store_edge;
  assign store_edge = (state_q == ST_IDLE) && cmd_valid_i && !cmd_i.run && cmd_i.keep
                      && (edge_total_q < ETW'(MaxEdges));
  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i && (!cmd_i.run || !out_ch.valid);

  always_comb begin
    ef_we    = store_edge;
    e_addr   = store_edge ? edge_total_q[EW-1:0] : e_q[EW-1:0];
    st_we    = 1'b0;
    st_addr  = SW'(depth_q - STW'(1));
    st_wd    = {v_q, e_q};
    fl_we    = 1'b0;
    fl_addr  = SW'(i_q - STW'(1));
    fl_wd    = v_q;
    vis_we   = 1'b0;
    vis_addr = b_q;
    vis_wd   = mark_q;
    case (state_q)
      ST_INIT: begin
        vis_we   = 1'b1;
        vis_addr = i_q[SW-1:0];
        vis_wd   = 1'b0;
      end
      ST_OUTER: begin
        vis_addr = i_q[SW-1:0];
      end
      ST_OUTER_CHK: begin
        vis_addr = i_q[SW-1:0];
        if (!vis_hit) begin
          vis_we  = 1'b1;
          st_we   = 1'b1;
          st_addr = '0;
          st_wd   = {i_q[SW-1:0], ETW'(0)};
        end
      end
      ST_EDGE: begin
        vis_addr = b_v;
      end
      ST_VIS: begin
        // The parent keeps the cursor past the edge that it follows.
        if (!vis_hit && depth_q < STW'(MaxVertices)) begin
          vis_we = 1'b1;
          st_we  = 1'b1;
          st_wd  = {v_q, ETW'(e_q + ETW'(1))};
        end
      end
      ST_PUSH: begin
        st_we = 1'b1;
      end
      ST_POP: begin
        if (backward_q && fin_total_q < STW'(MaxVertices)) begin
          fl_we   = 1'b1;
          fl_addr = fin_total_q[SW-1:0];
        end
      end
      ST_FIN_RD: begin
        vis_addr = fl_rd;
      end
      ST_FIN: begin
        vis_addr = fl_rd;
        if (!vis_hit) begin
          vis_we  = 1'b1;
          st_we   = 1'b1;
          st_addr = '0;
          st_wd   = {fl_rd, ETW'(0)};
        end
      end
      default: ;
    endcase
  end

  scc_ram #(.Width(8), .Depth(MaxEdges)) u_from (
    .clk_i, .we_i(ef_we), .addr_i(e_addr), .wdata_i(cmd_i.from_vertex), .rdata_o(ef_rd));
  scc_ram #(.Width(8), .Depth(MaxEdges)) u_to (
    .clk_i, .we_i(ef_we), .addr_i(e_addr), .wdata_i(cmd_i.to_vertex), .rdata_o(et_rd));
  scc_ram #(.Width(8 + ETW), .Depth(MaxVertices)) u_stack (
    .clk_i, .we_i(st_we), .addr_i(st_addr), .wdata_i(st_wd), .rdata_o(st_rd));
  scc_ram #(.Width(8), .Depth(MaxVertices)) u_fin (
    .clk_i, .we_i(fl_we), .addr_i(fl_addr), .wdata_i(fl_wd), .rdata_o(fl_rd));
  scc_ram #(.Width(1), .Depth(MaxVertices)) u_vis (
    .clk_i, .we_i(vis_we), .addr_i(vis_addr), .wdata_i(vis_wd), .rdata_o(vis_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      backward_q   <= 1'b1;
      mark_q       <= 1'b1;
      edge_total_q <= '0;
      e_q          <= '0;
      depth_q      <= '0;
      fin_total_q  <= '0;
      i_q          <= '0;
      count_q      <= '0;
      drop_q       <= 1'b0;
      v_q          <= '0;
      b_q          <= '0;
      out_ch.valid <= 1'b0;
      out_ch.component_count <= '0;
      out_ch.dropped_edges   <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state_q)
        // Clear every visited mark once after reset.
        ST_INIT: begin
          i_q <= i_q + STW'(1);
          if (i_q[SW-1:0] == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_pop_o) begin
            if (!cmd_i.run) begin
              if (store_edge) begin
                edge_total_q <= edge_total_q + ETW'(1);
              end else begin
                drop_q <= 1'b1;
              end
            end else begin
              e_q     <= '0;
              state_q <= ST_CHK_RD;
            end
          end
        end
        // Stored edges that fall outside the current vertex count set the flag.
        ST_CHK_RD: begin
          state_q <= (e_q < edge_total_q) ? ST_CHK : ST_CLR;
        end
        ST_CHK: begin
          if (10'(ef_rd) >= live || 10'(et_rd) >= live) begin
            drop_q <= 1'b1;
          end
          e_q     <= e_q + ETW'(1);
          state_q <= ST_CHK_RD;
        end
        ST_CLR: begin
          fin_total_q <= '0;
          i_q         <= '0;
          count_q     <= '0;
          backward_q  <= 1'b1;
          mark_q      <= 1'b1;
          state_q     <= ST_OUTER;
        end
        ST_OUTER: begin
          if (10'(i_q) >= live) begin
            backward_q <= 1'b0;
            mark_q     <= 1'b0;
            i_q        <= fin_total_q;
            state_q    <= ST_PASS2;
          end else begin
            state_q <= ST_OUTER_CHK;
          end
        end
        ST_OUTER_CHK: begin
          i_q <= i_q + STW'(1);
          if (!vis_hit) begin
            v_q     <= i_q[SW-1:0];
            e_q     <= '0;
            depth_q <= STW'(1);
            state_q <= ST_EDGE_RD;
          end else begin
            state_q <= ST_OUTER;
          end
        end
        ST_TOP_RD: begin
          state_q <= ST_TOP;
        end
        ST_TOP: begin
          v_q     <= st_rd[8+ETW-1:ETW];
          e_q     <= st_rd[ETW-1:0];
          state_q <= ST_EDGE_RD;
        end
        ST_EDGE_RD: begin
          state_q <= ST_EDGE;
        end
        ST_EDGE: begin
          if (e_q >= edge_total_q) begin
            state_q <= ST_POP;
          end else if (edge_hit) begin
            b_q     <= b_v;
            state_q <= ST_VIS;
          end else begin
            e_q     <= e_q + ETW'(1);
            state_q <= ST_EDGE_RD;
          end
        end
        ST_VIS: begin
          if (vis_hit) begin
            e_q     <= e_q + ETW'(1);
            state_q <= ST_EDGE_RD;
          end else if (depth_q < STW'(MaxVertices)) begin
            v_q     <= b_q;
            e_q     <= '0;
            depth_q <= depth_q + STW'(1);
            state_q <= ST_PUSH;
          end else begin
            // Stack full: the top vertex finishes at once.
            state_q <= ST_POP;
          end
        end
        // The new top is written while its first edge is read.
        ST_PUSH: begin
          state_q <= ST_EDGE;
        end
        ST_POP: begin
          if (backward_q && fin_total_q < STW'(MaxVertices)) begin
            fin_total_q <= fin_total_q + STW'(1);
          end
          depth_q <= depth_q - STW'(1);
          state_q <= (depth_q == STW'(1)) ? (backward_q ? ST_OUTER : ST_PASS2)
                                          : ST_TOP_RD;
        end
        ST_PASS2: begin
          state_q <= (i_q == '0) ? ST_DONE : ST_FIN_RD;
        end
        ST_FIN_RD: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          i_q <= i_q - STW'(1);
          if (!vis_hit) begin
            count_q <= count_q + 9'd1;
            v_q     <= fl_rd;
            e_q     <= '0;
            depth_q <= STW'(1);
            state_q <= ST_EDGE_RD;
          end else begin
            state_q <= ST_PASS2;
          end
        end
        ST_DONE: begin
          out_ch.valid           <= 1'b1;
          out_ch.component_count <= count_q;
          out_ch.dropped_edges   <= drop_q;
          edge_total_q           <= '0;
          drop_q                 <= 1'b0;
          state_q                <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/scc_counter_core.sv
// Top level of the strongly connected component counter.
// Usage:
//   in_ch takes one transaction per item: kind 0 stores a directed edge
//   (from_vertex, to_vertex), kind 1 runs a component count. The front end
//   range checks edges into a four-entry command queue; in_ch.ready drops
//   while that queue is full.
//   out_ch returns one transaction per run: component_count and
//   dropped_edges. Edge items return nothing.
//   cfg_we_i/cfg_wdata_i write vertex_count; write only while idle.
// Timing:
//   While idle, the engine takes one queued edge per cycle, so edges stream
//   back to back. A run does the range check over the stored edges, the
//   two outer loops and the two walks, with each vertex scanning the edge
//   list once from its saved cursor. The edge memory port sets the pace.
// Reset: edge store empty, flag clear, vertex_count 1. A pass over all 256
//   visited marks clears them; commands wait in the queue until it ends.
// Stall: a result waits in the output register; a run behind it waits at
//   the head of the queue, and in_ch.ready drops once the queue fills.
module scc_counter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  scc_in_if.sink     in_ch,
  scc_out_if.source  out_ch,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i
);
  logic [8:0]    vertex_count_q;
  logic          cmd_valid, cmd_pop;
  scc_pkg::cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= 9'd1;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  scc_front u_front (
    .clk_i, .rst_ni, .in_ch, .vertex_count_i(vertex_count_q),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop));

  scc_engine u_engine (
    .clk_i, .rst_ni, .vertex_count_i(vertex_count_q),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop), .out_ch);
endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the strongly connected component counter.
module tb_top;

  typedef struct {
    scc_pkg::kind_e kind;
    logic [7:0]     from_vertex;
    logic [7:0]     to_vertex;
  } scc_item_t;

  typedef struct {
    logic [8:0] component_count;
    logic       dropped_edges;
  } scc_result_t;

  localparam int NumVertices = 256;
  localparam int NumEdges    = 1024;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;

  scc_in_if  in_ch();
  scc_out_if out_ch();

  scc_counter_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  scc_item_t   item_q[$];
  scc_result_t count_q[$];
  int          fail_count = 0;
  int          run_count = 0;
  int          edge_count = 0;

  // Shadow copy of the block's graph state.
  int unsigned vcount = 1;
  int unsigned graph_from[NumEdges];
  int unsigned graph_to[NumEdges];
  int unsigned graph_total = 0;
  bit          graph_drop = 1'b0;
  bit          seen[NumVertices];
  int unsigned finish_order[NumVertices];
  int unsigned finish_total;
  int unsigned walk_vertex[NumVertices];
  int unsigned walk_cursor[NumVertices];

  function automatic int unsigned live_count();
    return (vcount > NumVertices) ? NumVertices : vcount;
  endfunction

  function automatic void dfs(int unsigned start, int unsigned n, bit backward, bit record);
    int unsigned depth;
    int unsigned v, a, b, e;
    bit pushed;
    seen[start] = 1'b1;
    walk_vertex[0] = start;
    walk_cursor[0] = 0;
    depth = 1;
    while (depth > 0) begin
      v = walk_vertex[depth-1];
      pushed = 1'b0;
      for (e = walk_cursor[depth-1]; e < graph_total; e++) begin
        a = backward ? graph_to[e] : graph_from[e];
        b = backward ? graph_from[e] : graph_to[e];
        if (a != v || a >= n || b >= n || seen[b]) continue;
        walk_cursor[depth-1] = e + 1;
        if (depth < NumVertices) begin
          seen[b] = 1'b1;
          walk_vertex[depth] = b;
          walk_cursor[depth] = 0;
          depth++;
          pushed = 1'b1;
        end
        break;
      end
      if (!pushed) begin
        depth--;
        if (record && finish_total < NumVertices) begin
          finish_order[finish_total] = v;
          finish_total++;
        end
      end
    end
  endfunction

  function automatic scc_result_t count_components();
    scc_result_t r;
    int unsigned n, i, e, cnt;
    n = live_count();
    cnt = 0;
    for (e = 0; e < graph_total; e++)
      if (graph_from[e] >= n || graph_to[e] >= n) graph_drop = 1'b1;
    foreach (seen[k]) seen[k] = 1'b0;
    finish_total = 0;
    for (i = 0; i < n; i++)
      if (!seen[i]) dfs(i, n, 1'b1, 1'b1);
    foreach (seen[k]) seen[k] = 1'b0;
    for (i = finish_total; i > 0; i--) begin
      if (seen[finish_order[i-1]]) continue;
      cnt++;
      dfs(finish_order[i-1], n, 1'b0, 1'b0);
    end
    r.component_count = cnt[8:0];
    r.dropped_edges   = graph_drop;
    graph_total = 0;
    graph_drop  = 1'b0;
    return r;
  endfunction

  // Input side: burst driver at the falling edge.
  bit taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = scc_pkg::KIND_EDGE;
    in_ch.from_vertex = '0;
    in_ch.to_vertex = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    logic next_valid;
    next_valid = in_ch.valid;
    if (!in_ch.valid || taken) begin
      taken = 1'b0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (gap_left > 0 || !rst_ni) begin
        next_valid = 1'b0;
        gap_left--;
      end else if (item_q.size() > 0) begin
        in_ch.kind        <= item_q[0].kind;
        in_ch.from_vertex <= item_q[0].from_vertex;
        in_ch.to_vertex   <= item_q[0].to_vertex;
        next_valid = 1'b1;
        burst_left--;
      end else begin
        next_valid = 1'b0;
      end
    end
    in_ch.valid <= next_valid;
  end

  // Each accepted input transaction updates the shadow state.
  always @(posedge clk_i) begin
    int unsigned n;
    scc_result_t res;
    if (in_ch.valid && in_ch.ready) begin
      taken = 1'b1;
      if (item_q[0].kind == scc_pkg::KIND_RUN) begin
        res = count_components();
        count_q = {count_q, res};
        run_count++;
      end else begin
        n = live_count();
        edge_count++;
        if (graph_total >= NumEdges || item_q[0].from_vertex >= n ||
            item_q[0].to_vertex >= n) begin
          graph_drop = 1'b1;
        end else begin
          graph_from[graph_total] = item_q[0].from_vertex;
          graph_to[graph_total]   = item_q[0].to_vertex;
          graph_total++;
        end
      end
      item_q.pop_front();
    end
  end

  // Output side: ready follows a stall mode that changes every so often.
  int stall_mode = 0;
  int cycle_n = 0;
  always @(negedge clk_i) begin
    cycle_n++;
    if (cycle_n % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ((cycle_n % 16) < 4);
      default: out_ch.ready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (count_q.size() == 0) begin
        $display("%0t: unexpected result count=%0d dropped=%0b", $time,
                 out_ch.component_count, out_ch.dropped_edges);
        fail_count++;
      end else begin
        if (out_ch.component_count !== count_q[0].component_count ||
            out_ch.dropped_edges !== count_q[0].dropped_edges) begin
          $display("%0t: mismatch expected count=%0d dropped=%0b actual count=%0d dropped=%0b",
                   $time, count_q[0].component_count, count_q[0].dropped_edges,
                   out_ch.component_count, out_ch.dropped_edges);
          fail_count++;
        end
        count_q.pop_front();
      end
    end
  end

  task automatic add_edge(int unsigned f, int unsigned t);
    scc_item_t it;
    it.kind = scc_pkg::KIND_EDGE;
    it.from_vertex = f[7:0];
    it.to_vertex = t[7:0];
    item_q = {item_q, it};
  endtask

  task automatic add_run();
    scc_item_t it;
    it.kind = scc_pkg::KIND_RUN;
    it.from_vertex = 8'($urandom_range(0, 255));
    it.to_vertex = 8'($urandom_range(0, 255));
    item_q = {item_q, it};
  endtask

  // Edges cause no result, so an extra wait after the queues empty lets the command queue drain.
  task automatic settle();
    @(posedge clk_i);
    while (item_q.size() > 0 || count_q.size() > 0 || in_ch.valid) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_vcount(int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value[8:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    vcount = value & 9'h1FF;
  endtask

  // One random graph of small size, usually followed by a run.
  task automatic random_graph(int unsigned n);
    int unsigned edges, k, lim;
    lim = (n > 64) ? 12 : 30;
    edges = $urandom_range(0, lim);
    for (k = 0; k < edges; k++) begin
      if ($urandom_range(0, 19) == 0)
        add_edge($urandom_range(0, 255), $urandom_range(0, 255));
      else
        add_edge($urandom_range(0, (n > 0 ? n : 1) - 1) & 8'hFF,
                 $urandom_range(0, (n > 0 ? n : 1) - 1) & 8'hFF);
    end
    if ($urandom_range(0, 9) != 0) add_run();
  endtask

  initial begin
    int unsigned n, k, g;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset count, single vertex, extremes of the register.
    add_run();
    add_edge(0, 0);
    add_edge(1, 0);
    add_run();
    settle();
    write_vcount(0);
    add_edge(0, 0);
    add_run();
    settle();
    write_vcount(256);
    add_edge(255, 0);
    add_edge(0, 255);
    add_edge(128, 128);
    add_run();
    settle();
    write_vcount(511);
    add_edge(255, 255);
    add_edge(170, 85);
    add_edge(85, 170);
    add_run();
    settle();
    // A full edge store drops everything past capacity.
    write_vcount(4);
    for (k = 0; k < NumEdges + 6; k++) add_edge($urandom_range(0, 3), $urandom_range(0, 3));
    add_run();
    settle();
    // Shrinking the vertex count after loading invalidates stored edges.
    write_vcount(16);
    add_edge(15, 3);
    add_edge(3, 15);
    add_edge(2, 3);
    settle();
    write_vcount(8);
    add_run();
    settle();

    // Random part.
    while (edge_count + run_count < 1700) begin
      case ($urandom_range(0, 19))
        0: n = 0;
        1: n = 256;
        2: n = $urandom_range(257, 511);
        3: n = 1;
        4: n = $urandom_range(65, 255);
        default: n = $urandom_range(2, 24);
      endcase
      write_vcount(n);
      n = (n > 256) ? 256 : n;
      for (g = 0; g < $urandom_range(2, 6); g++) random_graph(n);
      settle();
    end

    settle();
    $display("Covered %0d edge items and %0d runs, vertex counts 0 through 511.",
             edge_count, run_count);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d items and %0d results outstanding.",
             item_q.size(), count_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
